[rtl/vn3_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vn3_pkg: shared types and constants
// Beat payloads of the 3D vector normalizer and its pipeline depths.
// ---------------------------------------------------------------------------
package vn3_pkg;

   localparam int COMP_W   = 32;
   localparam int LANES    = 3;
   localparam int SQ_LAT   = 2;
   localparam int SUM_LAT  = 1;
   localparam int NORM_LAT = 5;
   localparam int ROOT_W   = 32;
   localparam int ROOT_LAT = NORM_LAT + ROOT_W;
   localparam int QUOT_W   = 31;
   localparam int DIV_LAT  = QUOT_W;
   localparam int TOT_LAT  = SQ_LAT + SUM_LAT + ROOT_LAT + DIV_LAT + 1;

   localparam logic [QUOT_W-1:0] UNIT_ONE = QUOT_W'(32'h4000_0000);

   typedef struct packed {
      logic signed [COMP_W-1:0] comp_x;
      logic signed [COMP_W-1:0] comp_y;
      logic signed [COMP_W-1:0] comp_z;
   } req_type;

   typedef struct packed {
      logic signed [COMP_W-1:0] unit_x;
      logic signed [COMP_W-1:0] unit_y;
      logic signed [COMP_W-1:0] unit_z;
      logic [COMP_W-1:0]        length;
      logic                     zero_vector;
   } rsp_type;

endpackage

[rtl/vn3_chan_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vn3_chan_if: valid/ready channel
// Carries one payload beat per valid and ready handshake.
// ---------------------------------------------------------------------------
interface vn3_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[rtl/vn3_square.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vn3_square: one component lane, front end
// Takes the magnitude and sign of a component and squares the magnitude.
// ---------------------------------------------------------------------------
module vn3_square (
   input  logic                               clock,
   input  logic                               en,
   input  logic signed [vn3_pkg::COMP_W-1:0]  comp,
   output logic [vn3_pkg::COMP_W-1:0]         mag,
   output logic                               neg,
   output logic [2*vn3_pkg::COMP_W-1:0]       sq
);
   import vn3_pkg::*;

   logic [COMP_W-1:0]   mag1_ff, mag2_ff;
   logic                neg1_ff, neg2_ff;
   logic [2*COMP_W-1:0] sq_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         neg1_ff <= comp[COMP_W-1];
         mag1_ff <= comp[COMP_W-1] ? COMP_W'(-comp) : COMP_W'(comp);
         neg2_ff <= neg1_ff;
         mag2_ff <= mag1_ff;
         sq_ff   <= mag1_ff * mag1_ff;
      end
   end

   assign mag = mag2_ff;
   assign neg = neg2_ff;
   assign sq  = sq_ff;
endmodule

[rtl/vn3_root.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vn3_root: normalizer and square root
// Shifts the sum of squares left by an even amount, then takes the integer
// square root one result bit per stage.
// ---------------------------------------------------------------------------
module vn3_root (
   input  logic                           clock,
   input  logic                           en,
   input  logic [2*vn3_pkg::COMP_W-1:0]   sum,
   output logic [vn3_pkg::ROOT_W-1:0]     root,
   output logic [4:0]                     shift
);
   import vn3_pkg::*;

   logic [2*COMP_W-1:0] norm_ff [NORM_LAT];
   logic [4:0]          nk_ff   [NORM_LAT];
   logic [2*COMP_W-1:0] src_ff  [ROOT_W];
   logic [ROOT_W:0]     rem_ff  [ROOT_W];
   logic [ROOT_W-1:0]   res_ff  [ROOT_W];
   logic [4:0]          k_ff    [ROOT_W];

   // normalize: each stage tests the top field and shifts by an even amount
   for (genvar j = 0; j < NORM_LAT; j++) begin : g_norm
      localparam int SH = 32 >> j;
      logic [2*COMP_W-1:0] src;
      logic [4:0]          kin;
      if (j == 0) begin : g_first
         assign src = sum;
         assign kin = '0;
      end else begin : g_next
         assign src = norm_ff[j-1];
         assign kin = nk_ff[j-1];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            if (src[2*COMP_W-1 -: SH] == '0) begin
               norm_ff[j] <= src << SH;
               nk_ff[j]   <= kin + 5'(SH / 2);
            end else begin
               norm_ff[j] <= src;
               nk_ff[j]   <= kin;
            end
         end
      end
   end

   // restoring square root, one bit per stage
   for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
      logic [2*COMP_W-1:0] src;
      logic [ROOT_W:0]     rem;
      logic [ROOT_W-1:0]   res;
      logic [4:0]          kin;
      logic [ROOT_W+2:0]   rem_t, trial;
      if (i == 0) begin : g_first
         assign src = norm_ff[NORM_LAT-1];
         assign rem = '0;
         assign res = '0;
         assign kin = nk_ff[NORM_LAT-1];
      end else begin : g_next
         assign src = src_ff[i-1];
         assign rem = rem_ff[i-1];
         assign res = res_ff[i-1];
         assign kin = k_ff[i-1];
      end
      assign rem_t = {rem, src[2*COMP_W-1 -: 2]};
      assign trial = {1'b0, res, 2'b01};
      always_ff @(posedge clock) begin
         if (en) begin
            src_ff[i] <= src << 2;
            k_ff[i]   <= kin;
            if (rem_t >= trial) begin
               rem_ff[i] <= (ROOT_W+1)'(rem_t - trial);
               res_ff[i] <= {res[ROOT_W-2:0], 1'b1};
            end else begin
               rem_ff[i] <= rem_t[ROOT_W:0];
               res_ff[i] <= {res[ROOT_W-2:0], 1'b0};
            end
         end
      end
   end

   assign root  = res_ff[ROOT_W-1];
   assign shift = k_ff[ROOT_W-1];
endmodule

[rtl/vn3_divide.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vn3_divide: one component lane, back end
// Divides the scaled magnitude by the root, one quotient bit per stage.
// ---------------------------------------------------------------------------
module vn3_divide (
   input  logic                           clock,
   input  logic                           en,
   input  logic [vn3_pkg::COMP_W-1:0]     mag,
   input  logic                           neg_in,
   input  logic [4:0]                     shift,
   input  logic [vn3_pkg::ROOT_W-1:0]     root,
   output logic [vn3_pkg::QUOT_W-1:0]     quot,
   output logic                           neg_out
);
   import vn3_pkg::*;

   logic [ROOT_W-1:0] rem_ff [DIV_LAT];
   logic [ROOT_W-1:0] div_ff [DIV_LAT];
   logic [QUOT_W-1:0] q_ff   [DIV_LAT];
   logic              neg_ff [DIV_LAT];
   logic [ROOT_W-1:0] scaled;
   logic [2*COMP_W-2:0] wide;

   // the scaled magnitude never exceeds the root, so it fits in one word
   assign wide   = {(COMP_W-1)'(0), mag} << shift;
   assign scaled = wide[ROOT_W-1:0];

   always_ff @(posedge clock) begin
      if (en) begin
         div_ff[0] <= root;
         neg_ff[0] <= neg_in;
         if (scaled >= root) begin
            rem_ff[0] <= scaled - root;
            q_ff[0]   <= QUOT_W'(1);
         end else begin
            rem_ff[0] <= scaled;
            q_ff[0]   <= '0;
         end
      end
   end

   for (genvar i = 1; i < DIV_LAT; i++) begin : g_step
      logic [ROOT_W:0] rem_t;
      assign rem_t = {rem_ff[i-1], 1'b0};
      always_ff @(posedge clock) begin
         if (en) begin
            div_ff[i] <= div_ff[i-1];
            neg_ff[i] <= neg_ff[i-1];
            if (rem_t >= {1'b0, div_ff[i-1]}) begin
               rem_ff[i] <= ROOT_W'(rem_t - {1'b0, div_ff[i-1]});
               q_ff[i]   <= {q_ff[i-1][QUOT_W-2:0], 1'b1};
            end else begin
               rem_ff[i] <= rem_t[ROOT_W-1:0];
               q_ff[i]   <= {q_ff[i-1][QUOT_W-2:0], 1'b0};
            end
         end
      end
   end

   assign quot    = q_ff[DIV_LAT-1];
   assign neg_out = neg_ff[DIV_LAT-1];
endmodule

[rtl/vector_normalize_3d_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vector_normalize_3d_core: 3D vector normalizer
// Gives the unit vector (Q1.30) and the length (Q16.16) of a Q16.16 vector.
// ---------------------------------------------------------------------------
// Usage:
//   req_chan carries one vector per beat (comp_x, comp_y, comp_z, Q16.16).
//   rsp_chan returns one result per request, in order: unit_x/y/z in Q1.30,
//   length = floor of the Euclidean length in Q16.16, and zero_vector, set
//   with all other fields zero when the input is the zero vector.
//   The path from request beat to response valid runs through the lane
//   squarers, the sum, the normalizing shift, the square root (one bit per
//   stage), the lane dividers (one quotient bit per stage) and the output
//   register. Throughput is one vector per cycle while rsp_chan does not
//   stall; three lanes square and divide the components side by side
//   around one shared root pipeline.
//   When rsp_chan stalls a valid beat, the whole pipeline holds and
//   req_chan.ready drops; bubbles are still taken in while the output is
//   empty. Synchronous reset clears the valid pipeline; the block has no
//   configuration and keeps no state between vectors.
// ---------------------------------------------------------------------------
module vector_normalize_3d_core (
   input  logic clock,
   input  logic reset,
   vn3_chan_if.sink   req_chan,
   vn3_chan_if.source rsp_chan
);
   import vn3_pkg::*;

   localparam int MID_LAT = ROOT_LAT + 1;

   logic                   en;
   logic [TOT_LAT-1:0]     vld_ff;
   logic signed [COMP_W-1:0] comp [LANES];
   logic [COMP_W-1:0]      mag [LANES];
   logic                   neg [LANES];
   logic [2*COMP_W-1:0]    sq  [LANES];
   logic [2*COMP_W-1:0]    sum_ff;
   logic                   zero_ff;
   logic [ROOT_W-1:0]      root;
   logic [4:0]             shift;
   logic [COMP_W-1:0]      mag_dly_ff [MID_LAT][LANES];
   logic                   neg_dly_ff [MID_LAT][LANES];
   logic                   zero_a_ff  [ROOT_LAT];
   logic                   zero_b_ff  [DIV_LAT];
   logic [COMP_W-1:0]      len_ff     [DIV_LAT];
   logic [QUOT_W-1:0]      quot [LANES];
   logic                   qneg [LANES];
   logic signed [COMP_W-1:0] unit [LANES];
   rsp_type                rsp_ff;

   assign en = !vld_ff[TOT_LAT-1] || rsp_chan.ready;
   assign req_chan.ready = en;

   assign comp[0] = req_chan.data.comp_x;
   assign comp[1] = req_chan.data.comp_y;
   assign comp[2] = req_chan.data.comp_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[TOT_LAT-2:0], req_chan.valid};
      end
   end

   for (genvar l = 0; l < LANES; l++) begin : g_front
      vn3_square u_square (
         .clock (clock),
         .en    (en),
         .comp  (comp[l]),
         .mag   (mag[l]),
         .neg   (neg[l]),
         .sq    (sq[l])
      );
   end

   // merge the lanes into the sum of squares
   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff  <= sq[0] + sq[1] + sq[2];
         zero_ff <= (sq[0] | sq[1] | sq[2]) == '0;
      end
   end

   vn3_root u_root (
      .clock (clock),
      .en    (en),
      .sum   (sum_ff),
      .root  (root),
      .shift (shift)
   );

   // carry lane magnitudes and the zero flag alongside the root pipeline
   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < LANES; l++) begin
            mag_dly_ff[0][l] <= mag[l];
            neg_dly_ff[0][l] <= neg[l];
            for (int d = 1; d < MID_LAT; d++) begin
               mag_dly_ff[d][l] <= mag_dly_ff[d-1][l];
               neg_dly_ff[d][l] <= neg_dly_ff[d-1][l];
            end
         end
         zero_a_ff[0] <= zero_ff;
         for (int d = 1; d < ROOT_LAT; d++) begin
            zero_a_ff[d] <= zero_a_ff[d-1];
         end
         zero_b_ff[0] <= zero_a_ff[ROOT_LAT-1];
         len_ff[0]    <= root >> shift;
         for (int d = 1; d < DIV_LAT; d++) begin
            zero_b_ff[d] <= zero_b_ff[d-1];
            len_ff[d]    <= len_ff[d-1];
         end
      end
   end

   for (genvar l = 0; l < LANES; l++) begin : g_back
      logic [QUOT_W-1:0] qsat;
      vn3_divide u_divide (
         .clock   (clock),
         .en      (en),
         .mag     (mag_dly_ff[MID_LAT-1][l]),
         .neg_in  (neg_dly_ff[MID_LAT-1][l]),
         .shift   (shift),
         .root    (root),
         .quot    (quot[l]),
         .neg_out (qneg[l])
      );
      assign qsat    = (quot[l] > UNIT_ONE) ? UNIT_ONE : quot[l];
      assign unit[l] = qneg[l] ? -COMP_W'(qsat) : COMP_W'(qsat);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (zero_b_ff[DIV_LAT-1]) begin
            rsp_ff <= '{unit_x: '0, unit_y: '0, unit_z: '0, length: '0,
                        zero_vector: 1'b1};
         end else begin
            rsp_ff <= '{unit_x: unit[0], unit_y: unit[1], unit_z: unit[2],
                        length: len_ff[DIV_LAT-1], zero_vector: 1'b0};
         end
      end
   end

   assign rsp_chan.valid = vld_ff[TOT_LAT-1];
   assign rsp_chan.data  = rsp_ff;

   a_zero_clears : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.data.zero_vector |->
         rsp_chan.data.length == '0 && rsp_chan.data.unit_x == '0 &&
         rsp_chan.data.unit_y == '0 && rsp_chan.data.unit_z == '0)
      else $error("zero vector beat with nonzero fields");

   a_length_nonzero : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.data.zero_vector |->
         rsp_chan.data.length != '0)
      else $error("nonzero vector gave zero length");

   // the quotients belong to the beat one stage short of the output register
   a_quot_bound : assert property (@(posedge clock) disable iff (reset)
      vld_ff[TOT_LAT-2] && !zero_b_ff[DIV_LAT-1] |->
         quot[0] <= UNIT_ONE && quot[1] <= UNIT_ONE && quot[2] <= UNIT_ONE)
      else $error("lane quotient above one");

   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |=> $stable(vld_ff) && !$past(en))
      else $error("pipeline advanced under a stalled response");
endmodule

[sim/vn3_result_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vn3_result_checker: result predictor and scoreboard
// Watches the request and response channels, predicts each normalized
// vector and compares it field by field against the returned beat.
// ---------------------------------------------------------------------------
module vn3_result_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  vn3_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  vn3_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending_count
);
   import vn3_pkg::*;

   rsp_type expected_q[$];

   function automatic logic [63:0] root64(logic [63:0] value);
      logic [63:0] res;
      logic [63:0] bitpos;
      res = 0;
      bitpos = 64'h1 << 62;
      while (bitpos > value) bitpos = bitpos >> 2;
      while (bitpos != 0) begin
         if (value >= res + bitpos) begin
            value = value - (res + bitpos);
            res = (res >> 1) + bitpos;
         end else begin
            res = res >> 1;
         end
         bitpos = bitpos >> 2;
      end
      return res;
   endfunction

   function automatic logic [31:0] scale_lane(logic [31:0] raw, int shift,
                                              logic [63:0] root);
      logic [63:0] mag;
      logic [63:0] quot;
      mag = raw[31] ? (64'h1_0000_0000 - {32'h0, raw}) : {32'h0, raw};
      quot = ((mag << shift) << 30) / root;
      if (quot > 64'h4000_0000) quot = 64'h4000_0000;
      if (raw[31]) quot = 64'h1_0000_0000 - quot;
      return quot[31:0];
   endfunction

   function automatic rsp_type normalize(req_type vec);
      rsp_type r;
      logic [31:0] raw[3];
      logic [63:0] mag;
      logic [63:0] sum_sq;
      logic [63:0] root;
      int shift;
      raw[0] = vec.comp_x;
      raw[1] = vec.comp_y;
      raw[2] = vec.comp_z;
      sum_sq = 0;
      for (int i = 0; i < 3; i++) begin
         mag = raw[i][31] ? (64'h1_0000_0000 - {32'h0, raw[i]}) : {32'h0, raw[i]};
         sum_sq = sum_sq + mag * mag;
      end
      r = '0;
      if (sum_sq == 0) begin
         r.zero_vector = 1'b1;
         return r;
      end
      shift = 0;
      while (sum_sq[63:62] == 2'b00) begin
         sum_sq = sum_sq << 2;
         shift++;
      end
      root = root64(sum_sq);
      r.unit_x = scale_lane(raw[0], shift, root);
      r.unit_y = scale_lane(raw[1], shift, root);
      r.unit_z = scale_lane(raw[2], shift, root);
      r.length = 32'(root >> shift);
      return r;
   endfunction

   assign pending_count = expected_q.size();

   initial fail_count = 0;

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) expected_q.push_back(normalize(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result beat: %p", rsp_data);
            end else begin
               want = expected_q.pop_front();
               if (rsp_data !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: expected %p, got %p", want, rsp_data);
               end
            end
         end
      end
   end

endmodule

[sim/vector_normalize_3d_core_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vector_normalize_3d_core_test: normalizer testbench top
// Drives directed and random vectors with random idling on both channels;
// the checker predicts every result and counts mismatches.
// ---------------------------------------------------------------------------
module vector_normalize_3d_core_test;
   import vn3_pkg::*;

   localparam int RANDOM_ITEMS = 400;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_count;
   bit   busy_stretch;

   vn3_chan_if #(.payload_type(req_type)) req_chan ();
   vn3_chan_if #(.payload_type(rsp_type)) rsp_chan ();

   vector_normalize_3d_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   vn3_result_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_ready     (req_chan.ready),
      .req_data      (req_chan.data),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_data      (rsp_chan.data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("CHECKS FAILED");
      $finish;
   end

   // response side: stall about 8 percent of the time outside the busy stretch
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready <= busy_stretch || ($urandom_range(99) >= 8);
      end
   end

   function automatic logic [31:0] random_comp();
      case ($urandom_range(5))
         0: return $urandom;
         1: return 32'($signed($urandom_range(255)) - 128);
         2: return {{16{1'($urandom_range(1))}}, 16'($urandom)};
         3: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
         4: return 32'h0;
         default: return 32'($signed($urandom_range(65536 * 4)) - 131072);
      endcase
   endfunction

   task automatic send_vector(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      logic accepted;
      if (!busy_stretch)
         while ($urandom_range(99) < 8) begin
            req_chan.valid <= 1'b0;
            @(negedge clock);
         end
      req_chan.valid <= 1'b1;
      req_chan.data  <= '{comp_x: x, comp_y: y, comp_z: z};
      // sample ready once it has settled after the falling edge
      do begin
         #1;
         accepted = req_chan.ready;
         @(posedge clock);
         if (!accepted) @(negedge clock);
      end while (!accepted);
      @(negedge clock);
   endtask

   initial begin
      logic [31:0] edge_vals[8];
      int wait_cycles;
      edge_vals = '{32'h0, 32'h1, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                    32'h0001_0000, 32'hffff_0000, 32'h8000_0001};
      busy_stretch   = 1'b0;
      reset          = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.data  = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: zero vector, extremes, single axes, rounding past one
      send_vector(0, 0, 0);
      send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_vector(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      send_vector(32'h8000_0000, 0, 0);
      send_vector(0, 32'h7fff_ffff, 0);
      send_vector(0, 0, 32'hffff_ffff);
      send_vector(1, 0, 0);
      send_vector(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      send_vector(32'hffff_0000, 32'h0002_0000, 32'h0002_0000);
      send_vector(3, 4, 0);
      send_vector(32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0001);
      for (int i = 0; i < 8; i++)
         send_vector(edge_vals[i], edge_vals[7 - i], edge_vals[(i + 3) % 8]);

      // hold until the pipeline drains completely
      req_chan.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         busy_stretch = (n >= 150 && n < 250);
         send_vector(random_comp(), random_comp(), random_comp());
      end
      busy_stretch = 1'b0;
      req_chan.valid <= 1'b0;

      wait_cycles = 0;
      while (pending_count != 0 && wait_cycles < 100000) begin
         @(negedge clock);
         wait_cycles++;
      end
      repeat (TOT_LAT + 10) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
